// ===== design/mt64_pkg.sv =====
package mt64_pkg;

  localparam int StateWords   = 312;
  localparam int MiddleOffset = 156;
  localparam int IdxW         = 9;
  localparam int RawW         = 53;

  localparam logic [63:0] SeedReset   = 64'd5489;
  localparam logic [63:0] TwistMatrix = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UpperMask   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LowerMask   = 64'h000000007FFFFFFF;
  localparam logic [63:0] InitMult    = 64'd6364136223846793005;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ACC,
    ST_TW_RD0,
    ST_TW_RD1,
    ST_TW_RD2,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_WAIT,
    ST_CONV,
    ST_DIV,
    ST_DONE
  } state_t;

  // Temper one raw state word.
  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] y;
    y = w;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

// ===== design/mt64_mul.sv =====
// 64x64 low-half multiplier built from three registered 32x32 partial products.
module mt64_mul (
  input  logic        clk,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import mt64_pkg::*;

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // Partial products, registered.
  always_ff @(posedge clk) begin
    if (start) begin
      ll <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
    end
  end

  // Final combine of the registered partials.
  assign p = ll + {lh + hl, 32'd0};
endmodule

// ===== design/mt64_div.sv =====
// Scales raw by 1/(2^53-1). The binary expansion of raw/(2^53-1) repeats raw every
// 53 bits, so the rounded double is the normalized raw plus one ulp.
module mt64_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [52:0] raw,
  output logic        busy,
  output logic [63:0] bits
);
  import mt64_pkg::*;

  localparam logic [52:0] RawMax  = {53{1'b1}};
  localparam logic [10:0] ExpHalf = 11'd1022;
  localparam logic [10:0] ExpOne  = 11'd1023;

  logic [52:0] sig;
  logic [10:0] exp_v;
  logic        zero;
  logic        one;
  logic [51:0] frac_up;

  // Shift the value left one bit per cycle until its leading one reaches the top bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      sig   <= raw;
      exp_v <= ExpHalf;
      zero  <= (raw == '0);
      one   <= (raw == RawMax);
    end else if (busy) begin
      if (zero || sig[52]) begin
        busy <= 1'b0;
      end else begin
        sig   <= {sig[51:0], 1'b0};
        exp_v <= exp_v - 11'd1;
      end
    end
  end

  // The bits past the significand start with the leading one again and never end,
  // so the value always rounds up by one ulp. The significand is never all ones
  // here, so the increment cannot carry into the hidden bit.
  assign frac_up = sig[51:0] + 52'd1;

  // Pack the double; the all-ones raw value is exactly 1.0.
  always_comb begin
    if (zero) begin
      bits = 64'd0;
    end else if (one) begin
      bits = {1'b0, ExpOne, 52'd0};
    end else begin
      bits = {1'b0, exp_v, frac_up};
    end
  end
endmodule

// ===== design/mt64_real_closed_generator_core.sv =====
// After a request word is accepted, a result comes from a memory read, temper, then
// one normalize shift per leading zero of the 53-bit raw value. A draw that needs a twist
// first passes every state word through TW_RD0, TW_RD1, TW_RD2 and TW_WR.
// Seeding runs before the twist. One request is handled at a time; ready returns the
// cycle after the result is taken. Reset: seed returns to 5489, the state is marked
// unseeded, so the first request seeds the memory; memory contents are not cleared.
module mt64_real_closed_generator_core #(
  parameter int STATE_WORDS   = mt64_pkg::StateWords,
  parameter int MIDDLE_OFFSET = mt64_pkg::MiddleOffset
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] reseed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [119:0] m_axis_tdata,  // [63:0] sample_bits, [116:64] raw_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  import mt64_pkg::*;

  logic [63:0] mem [STATE_WORDS];
  logic [63:0] seed;
  logic [IdxW-1:0] rd_idx;
  logic        seeded;
  state_t      st, st_next;
  logic [IdxW-1:0] i;
  logic [63:0] prev;
  logic [63:0] rdata;
  logic [IdxW-1:0] raddr;
  logic [63:0] w_i, w_n;
  logic [63:0] mul_p;
  logic        mul_start;
  logic        div_start;
  logic        div_busy;
  logic [63:0] div_bits;
  logic [52:0] raw;
  logic [63:0] samp;
  logic        we;
  logic [IdxW-1:0] waddr;
  logic [63:0] wdata;
  logic [IdxW-1:0] i_nxt, i_mid;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) seed <= SeedReset;
    else if (cfg_valid) seed <= cfg_data;
  end

  mt64_mul u_mul (.clk(clk), .start(mul_start), .a(prev ^ (prev >> 62)),
                  .b(InitMult), .p(mul_p));
  mt64_div u_div (.clk(clk), .rst(rst), .start(div_start), .raw(raw),
                  .busy(div_busy), .bits(div_bits));

  assign i_nxt = (i == IdxW'(STATE_WORDS - 1)) ? '0 : i + 1'b1;
  assign i_mid = (i >= IdxW'(STATE_WORDS - MIDDLE_OFFSET)) ?
                 i - IdxW'(STATE_WORDS - MIDDLE_OFFSET) : i + IdxW'(MIDDLE_OFFSET);

  // State memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tdata[0] || !seeded) st_next = ST_SEED_MUL;
          else if (rd_idx >= IdxW'(STATE_WORDS)) st_next = ST_TW_RD0;
          else st_next = ST_DRAW_RD;
        end
      end
      ST_SEED_MUL: st_next = (i == IdxW'(STATE_WORDS)) ? ST_TW_RD0 : ST_SEED_ACC;
      ST_SEED_ACC: st_next = ST_SEED_MUL;
      ST_TW_RD0:   st_next = ST_TW_RD1;
      ST_TW_RD1:   st_next = ST_TW_RD2;
      ST_TW_RD2:   st_next = ST_TW_WR;
      ST_TW_WR:    st_next = (i == IdxW'(STATE_WORDS - 1)) ? ST_DRAW_RD : ST_TW_RD0;
      ST_DRAW_RD:  st_next = ST_DRAW_WAIT;
      ST_DRAW_WAIT: st_next = ST_CONV;
      ST_CONV:     st_next = ST_DIV;
      ST_DIV:      st_next = div_busy ? ST_DIV : ST_DONE;
      ST_DONE:     st_next = m_axis_tready ? ST_IDLE : ST_DONE;
      default:     st_next = ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    raddr = i;
    we = 1'b0;
    waddr = i;
    wdata = mul_p + {{(64-IdxW){1'b0}}, i};
    mul_start = 1'b0;
    div_start = 1'b0;
    case (st)
      ST_IDLE: begin
        if (s_axis_tvalid && (s_axis_tdata[0] || !seeded)) begin
          we = 1'b1;
          waddr = '0;
          wdata = seed;
        end
      end
      ST_SEED_MUL: mul_start = 1'b1;
      ST_SEED_ACC: we = 1'b1;
      ST_TW_RD0: raddr = i;
      ST_TW_RD1: raddr = i_nxt;
      ST_TW_RD2: raddr = i_mid;
      ST_TW_WR: begin
        we = 1'b1;
        wdata = rdata ^ (((w_i & UpperMask) | (w_n & LowerMask)) >> 1) ^
                (w_n[0] ? TwistMatrix : 64'd0);
      end
      ST_DRAW_RD: raddr = rd_idx;
      ST_CONV: div_start = 1'b1;
      default: ;
    endcase
  end

  assign s_axis_tready = (st == ST_IDLE);
  assign m_axis_tvalid = (st == ST_DONE);
  assign m_axis_tdata  = {3'd0, raw, samp};

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      seeded <= 1'b0;
      rd_idx <= IdxW'(STATE_WORDS);
      i <= '0;
    end else begin
      st <= st_next;
      case (st)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tdata[0] || !seeded) begin
              prev <= seed;
              i <= IdxW'(1);
              seeded <= 1'b1;
            end else begin
              i <= '0;
            end
          end
        end
        ST_SEED_MUL: if (i == IdxW'(STATE_WORDS)) i <= '0;
        ST_SEED_ACC: begin
          prev <= wdata;
          i <= i + 1'b1;
        end
        ST_TW_RD1: w_i <= rdata;
        ST_TW_RD2: w_n <= rdata;
        ST_TW_WR: begin
          i <= i_nxt;
          if (i == IdxW'(STATE_WORDS - 1)) rd_idx <= '0;
        end
        ST_DRAW_RD: ;
        ST_DRAW_WAIT: rd_idx <= rd_idx + 1'b1;
        default: ;
      endcase
    end
  end

  // Data path registers. The drawn word is on the read port only while the
  // draw waits, so it is tempered there.
  always_ff @(posedge clk) begin
    if (st == ST_DRAW_WAIT) raw <= 53'(temper(rdata) >> 11);
    if (st == ST_DIV && !div_busy) samp <= div_bits;
  end

  // A result is only offered when the sequencer is done.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("valid while ready");
  // The draw index never runs past the state size.
  a_idx: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= IdxW'(STATE_WORDS)) else $error("index overflow");
  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed");
endmodule
